### hdl/lslr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslr_pkg
// Shared types and codes for the LRU set lookup and replacement block.
// ----------------------------------------------------------------------------
package lslr_pkg;

  localparam logic [1:0] KIND_HIT      = 2'd0;
  localparam logic [1:0] KIND_COLD     = 2'd1;
  localparam logic [1:0] KIND_CONFLICT = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic eval;
    logic update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } ctrl_sts_t;

endpackage

### hdl/lslr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslr_ctrl
// Sequencer: clearing pass after reset, then capture, evaluate, write back.
// ----------------------------------------------------------------------------
module lslr_ctrl
  import lslr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd,
  output logic      busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_EVAL;
      end
      ST_EVAL:  state_next = ST_WRITE;
      ST_WRITE: state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_EVAL:  cmd.eval = 1'b1;
      ST_WRITE: cmd.update = 1'b1;
      default:  cmd = '0;
    endcase
  end

endmodule

### hdl/lslr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslr_dp
// Tag, valid and recency stores per set, way compare, victim choice and
// recency update.
// ----------------------------------------------------------------------------
module lslr_dp
  import lslr_pkg::*;
#(
  parameter int SETS     = 64,
  parameter int WAYS     = 4,
  parameter int TAG_BITS = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  ctrl_cmd_t  cmd,
  output ctrl_sts_t  sts,
  input  logic [5:0] set_index,
  input  logic [19:0] tag,
  output logic       done,
  output logic [1:0] access_kind,
  output logic [1:0] way
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int IDX_N = 64;

  typedef logic [WAYS-1:0][WAY_W-1:0]    order_row_t;
  typedef logic [WAYS-1:0][TAG_BITS-1:0] tag_row_t;

  order_row_t        order_mem [SETS];
  logic [WAYS-1:0]   valid_mem [SETS];
  tag_row_t          tag_mem   [SETS];

  logic [SET_W-1:0]  wrap_tbl [IDX_N];
  logic [SET_W-1:0]  set_wr;
  logic [TAG_BITS-1:0] tag_cut;

  logic [SET_W-1:0]  clr_addr;
  logic [SET_W-1:0]  set_q;
  logic [TAG_BITS-1:0] tag_q;
  order_row_t        rd_order;
  logic [WAYS-1:0]   rd_valid;
  tag_row_t          rd_tags;

  logic [WAY_W-1:0]  pos_q;
  logic [1:0]        kind_q;
  logic [WAY_W-1:0]  way_q;

  logic [WAY_W-1:0]  chosen_pos;
  logic [1:0]        chosen_kind;
  order_row_t        order_ident;
  order_row_t        order_new;
  logic [WAYS-1:0]   valid_new;

  // set index wraps modulo SETS
  for (genvar g = 0; g < IDX_N; g++) begin : g_wrap
    assign wrap_tbl[g] = SET_W'(g % SETS);
  end

  assign set_wr  = wrap_tbl[set_index];
  assign tag_cut = TAG_BITS'(tag);

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear && !sts.clear_last) begin
      clr_addr <= clr_addr + SET_W'(1);
    end
  end

  assign sts.clear_last = (clr_addr == SET_W'(SETS - 1));

  // capture and row read
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_q    <= set_wr;
      tag_q    <= tag_cut;
      rd_order <= order_mem[set_wr];
      rd_valid <= valid_mem[set_wr];
      rd_tags  <= tag_mem[set_wr];
    end
  end

  // hit search and victim choice in recency order
  always_comb begin
    logic             any_hit;
    logic             any_inv;
    logic [WAY_W-1:0] hit_pos;
    logic [WAY_W-1:0] inv_pos;
    logic [WAY_W-1:0] w;
    any_hit = 1'b0;
    any_inv = 1'b0;
    hit_pos = '0;
    inv_pos = '0;
    for (int p = WAYS - 1; p >= 0; p--) begin
      w = rd_order[p];
      if (rd_valid[w] && (rd_tags[w] == tag_q)) begin
        any_hit = 1'b1;
        hit_pos = WAY_W'(p);
      end
      if (!rd_valid[w]) begin
        any_inv = 1'b1;
        inv_pos = WAY_W'(p);
      end
    end
    if (any_hit) begin
      chosen_pos  = hit_pos;
      chosen_kind = KIND_HIT;
    end else if (any_inv) begin
      chosen_pos  = inv_pos;
      chosen_kind = KIND_COLD;
    end else begin
      chosen_pos  = WAY_W'(WAYS - 1);
      chosen_kind = KIND_CONFLICT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      pos_q  <= chosen_pos;
      kind_q <= chosen_kind;
      way_q  <= rd_order[chosen_pos];
    end
  end

  // promote chosen way to front
  always_comb begin
    for (int p = 0; p < WAYS; p++) begin
      order_ident[p] = WAY_W'(p);
      if (p == 0) begin
        order_new[p] = way_q;
      end else if (WAY_W'(p) <= pos_q) begin
        order_new[p] = rd_order[p-1];
      end else begin
        order_new[p] = rd_order[p];
      end
    end
    valid_new = rd_valid;
    if (kind_q != KIND_HIT) valid_new[way_q] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      order_mem[clr_addr] <= order_ident;
      valid_mem[clr_addr] <= '0;
    end else if (cmd.update) begin
      order_mem[set_q] <= order_new;
      valid_mem[set_q] <= valid_new;
      if (kind_q != KIND_HIT) tag_mem[set_q][way_q] <= tag_q;
    end
  end

  // result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      access_kind <= kind_q;
      way         <= 2'(way_q);
    end
  end

endmodule

### hdl/lru_set_lookup_replace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_set_lookup_replace
// Tag store with per-set LRU replacement for a set-associative cache.
// ----------------------------------------------------------------------------
//  channel   | handshake           | payload
//  ----------+---------------------+----------------------------
//  access in | start, busy         | set_index, tag
//  result    | done (strobe)       | access_kind, way
//
//  A transaction runs capture with row read, then way compare and
//  victim choice, then row write back; done pulses the cycle after write back.
//  The row memories have one access per cycle.
//  After reset a clearing pass over all SETS sets keeps busy high.
//  done is a single-cycle strobe; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module lru_set_lookup_replace
  import lslr_pkg::*;
#(
  parameter int SETS     = 64,
  parameter int WAYS     = 4,
  parameter int TAG_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  set_index,
  input  logic [19:0] tag,
  output logic        done,
  output logic [1:0]  access_kind,
  output logic [1:0]  way
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  lslr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  lslr_dp #(
    .SETS     (SETS),
    .WAYS     (WAYS),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .set_index   (set_index),
    .tag         (tag),
    .done        (done),
    .access_kind (access_kind),
    .way         (way)
  );

endmodule

### hdl/lslr_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslr_chk
// Port-level checks for the LRU set lookup block, bound to the top level.
// ----------------------------------------------------------------------------
module lslr_chk
  import lslr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  access_kind
);

  a_reset_busy: assert property (@(posedge clk) rst |=> busy && !done)
    else $error("busy low or done high right after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result strobe missing three cycles after accept");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && !$past(done))
    else $error("result strobe while busy or on consecutive cycles");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (access_kind == KIND_HIT || access_kind == KIND_COLD ||
              access_kind == KIND_CONFLICT))
    else $error("undefined access kind");

endmodule

bind lru_set_lookup_replace lslr_chk u_lslr_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .access_kind (access_kind)
);

### bench/lru_access_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_access_checker
// Watches the access and result channels of the LRU set lookup block. Every
// accepted access runs through a local tag store and recency model, and the
// predicted hit/miss kind and way are queued. Each done strobe is compared
// with the oldest queued outcome. Mismatches and unexpected strobes are
// counted and handed to the bench top.
// ----------------------------------------------------------------------------
module lru_access_checker
  import lslr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [5:0]  set_index,
  input  logic [19:0] tag,
  input  logic        done,
  input  logic [1:0]  access_kind,
  input  logic [1:0]  way,
  output int          fail_count,
  output int          outstanding
);

  localparam int NSETS = 64;
  localparam int NWAYS = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] way;
  } access_outcome_t;

  logic [NWAYS-1:0] valid_map [NSETS];
  logic [19:0]      tag_mem   [NSETS][NWAYS];
  logic [1:0]       recency   [NSETS][NWAYS];

  access_outcome_t pending_outcomes [$];

  // Recency list holds way numbers, most recent first.
  task automatic predict_lookup(input logic [5:0] s, input logic [19:0] t,
                                output access_outcome_t res);
    int         pos;
    int         chosen;
    logic       hit;
    logic       found;
    logic [1:0] w;
    hit    = 1'b0;
    found  = 1'b0;
    chosen = NWAYS - 1;
    res.kind = KIND_CONFLICT;
    for (pos = 0; pos < NWAYS; pos++) begin
      w = recency[s][pos];
      if (!hit && valid_map[s][w] && tag_mem[s][w] == t) begin
        hit    = 1'b1;
        chosen = pos;
      end
    end
    if (hit) begin
      res.kind = KIND_HIT;
    end else begin
      for (pos = 0; pos < NWAYS; pos++) begin
        w = recency[s][pos];
        if (!found && !valid_map[s][w]) begin
          found    = 1'b1;
          chosen   = pos;
          res.kind = KIND_COLD;
        end
      end
    end
    w = recency[s][chosen];
    if (!hit) begin
      valid_map[s][w] = 1'b1;
      tag_mem[s][w]   = t;
    end
    for (pos = chosen; pos > 0; pos--) begin
      recency[s][pos] = recency[s][pos-1];
    end
    recency[s][0] = w;
    res.way = w;
  endtask

  always @(posedge clk) begin : monitor
    int              i;
    int              j;
    access_outcome_t exp_o;
    access_outcome_t new_o;
    if (rst) begin
      for (i = 0; i < NSETS; i++) begin
        valid_map[i] = '0;
        for (j = 0; j < NWAYS; j++) begin
          recency[i][j] = j[1:0];
          tag_mem[i][j] = '0;
        end
      end
      pending_outcomes.delete();
      outstanding = 0;
      fail_count  = 0;
    end else begin
      if (done) begin
        if (pending_outcomes.size() == 0) begin
          $error("result transaction with no access pending: kind %0d way %0d",
                 access_kind, way);
          fail_count = fail_count + 1;
        end else begin
          exp_o = pending_outcomes.pop_front();
          if (access_kind !== exp_o.kind) begin
            $error("access_kind mismatch: expected %0d, got %0d",
                   exp_o.kind, access_kind);
            fail_count = fail_count + 1;
          end
          if (way !== exp_o.way) begin
            $error("way mismatch: expected %0d, got %0d", exp_o.way, way);
            fail_count = fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        predict_lookup(set_index, tag, new_o);
        pending_outcomes.push_back(new_o);
      end
      outstanding = pending_outcomes.size();
    end
  end

endmodule

### bench/tb_lru_set_lookup_replace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_set_lookup_replace
// Bench top for the LRU set lookup block. Drives a directed run of cold
// fills, hits and conflict evictions, then random access transactions that
// mostly land on a few hot sets with a small tag pool so hits and evictions
// are frequent. Sender gaps vary by phase. The checker does all prediction.
// ----------------------------------------------------------------------------
module tb_lru_set_lookup_replace;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int PHASE_ITEMS  = 135;
  localparam int POOL_TAGS    = 6;
  localparam int HOT_SETS     = 8;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [5:0]  set_index;
  logic [19:0] tag;
  logic        done;
  logic [1:0]  access_kind;
  logic [1:0]  way;
  int          fail_count;
  int          outstanding;
  int          cycle_count = 0;

  logic [19:0] tag_pool [64][POOL_TAGS];
  logic [5:0]  hot_set  [HOT_SETS];

  lru_set_lookup_replace dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .set_index   (set_index),
    .tag         (tag),
    .done        (done),
    .access_kind (access_kind),
    .way         (way)
  );

  lru_access_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .set_index   (set_index),
    .tag         (tag),
    .done        (done),
    .access_kind (access_kind),
    .way         (way),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_access(input logic [5:0] s, input logic [19:0] t);
    logic taken;
    start     = 1'b1;
    set_index = s;
    tag       = t;
    taken     = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end
  endtask

  task automatic idle_cycles(input int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int          ph;
    int          k;
    int          i;
    int          sel;
    int          idle_pct;
    logic [5:0]  s;
    logic [19:0] t;
    rst       = 1'b1;
    start     = 1'b0;
    set_index = '0;
    tag       = '0;
    for (i = 0; i < 64; i++) begin
      for (k = 0; k < POOL_TAGS; k++) begin
        tag_pool[i][k] = 20'($urandom_range(20'hFFFFF));
      end
    end
    for (i = 0; i < HOT_SETS; i++) begin
      hot_set[i] = 6'($urandom_range(63));
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // cold fills from reset order, hits, LRU eviction, back-to-back same set
    issue_access(6'd0,  20'h00000);
    issue_access(6'd0,  20'h00000);
    issue_access(6'd63, 20'hFFFFF);
    issue_access(6'd63, 20'hFFFFF);
    issue_access(6'd5,  20'h0000A);
    issue_access(6'd5,  20'h0000B);
    issue_access(6'd5,  20'h0000C);
    issue_access(6'd5,  20'h0000D);
    issue_access(6'd5,  20'h0000A);
    issue_access(6'd5,  20'h0000E);
    issue_access(6'd5,  20'h0000B);
    issue_access(6'd5,  20'h00000);
    issue_access(6'd5,  20'h0000D);
    issue_access(6'd63, 20'h00000);
    issue_access(6'd0,  20'hFFFFF);
    issue_access(6'd42, 20'h55555);
    issue_access(6'd21, 20'hAAAAA);
    issue_access(6'd21, 20'h55555);
    issue_access(6'd21, 20'hAAAAA);
    drain_results();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  end
        1: begin idle_pct = 48; end
        2: begin idle_pct = 33; end
        default: begin idle_pct = 0; end
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        sel = $urandom_range(99);
        if (sel < 70) begin
          s = hot_set[$urandom_range(HOT_SETS-1)];
          t = tag_pool[s][$urandom_range(POOL_TAGS-1)];
        end else if (sel < 85) begin
          s = 6'($urandom_range(63));
          t = tag_pool[s][$urandom_range(POOL_TAGS-1)];
        end else begin
          s = 6'($urandom_range(63));
          t = 20'($urandom_range(20'hFFFFF));
        end
        if ($urandom_range(99) < idle_pct) begin
          idle_cycles($urandom_range(1, 4));
        end
        issue_access(s, t);
      end
      drain_results();
    end

    start = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
